@@ rtl/assert_macros.svh @@
// Assertion macros for the CEC receiver RTL.
// Clocked on clk and disabled while rst is high; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/cecbr_pkg.sv @@
// Shared constants for the CEC bit receiver: field widths, register indexes,
// reset values. No dependencies.
package cecbr_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 16;

  localparam logic [CfgIdxW-1:0] RegOwnAddress = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMonitor    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartMin   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOneMax     = 3'd4;

  localparam logic [AddrW-1:0]    AddrBroadcast = 4'hF;
  localparam logic [CfgDataW-1:0] StartMinReset = 16'd3500;
  localparam logic [CfgDataW-1:0] OneMinReset   = 16'd400;
  localparam logic [CfgDataW-1:0] OneMaxReset   = 16'd800;
  localparam logic [3:0]          BitsPerByte   = 4'd8;

endpackage

@@ rtl/cec_bit_receiver.sv @@
// CEC bit receiver top level: edge classification, byte assembly, ack request.
// Depends on cecbr_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Takes one line-edge event per item and returns exactly one result item for
// it. An event is held in an input register, classified against the receive
// state by one 32-bit subtract and four compares against 16-bit limits, and
// the result is written to an output register, together with the updated
// state, once that register is free. One item per cycle is sustained while
// the output is not stalled. A waiting result does not block intake as
// long as the input register can move on. Configuration writes take effect at
// once and are meant for an idle block.
module cec_bit_receiver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [0] pin_level, [32:1] time_us, [39:33] zero
  input  logic [cecbr_pkg::InTdataW-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] byte_valid, [8:1] byte_value, [9] frame_abort, [10] ack_pulse,
  // [11] start_seen, [15:12] zero
  output logic [cecbr_pkg::OutTdataW-1:0]      m_tdata,
  output logic                                 m_tlast,
  input  logic                                 cfg_wen,
  input  logic [cecbr_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [cecbr_pkg::CfgDataW-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BYTE   = 3'd1,
    PH_EOM    = 3'd2,
    PH_ACK    = 3'd3,
    PH_EOMACK = 3'd4
  } phase_t;

  // configuration
  logic [cecbr_pkg::AddrW-1:0]    own_address;
  logic                           monitor_mode;
  logic [cecbr_pkg::CfgDataW-1:0] start_min_us, one_min_us, one_max_us;

  // input register
  logic                           in_v;
  logic                           in_level;
  logic [cecbr_pkg::TimeW-1:0]    in_time;

  // output register
  logic                           out_v;
  logic                           o_bvalid, o_last, o_abort, o_ack, o_start;
  logic [7:0]                     o_bval;

  // receive state
  logic                           prev_level, prev_level_next;
  logic [cecbr_pkg::TimeW-1:0]    fall_time, fall_time_next;
  phase_t                         phase, phase_next;
  logic [3:0]                     bit_count, bit_count_next;
  logic [7:0]                     shift_byte, shift_byte_next;
  logic [7:0]                     held_byte, held_byte_next;
  logic [cecbr_pkg::AddrW-1:0]    header_dest, header_dest_next;
  logic                           frame_open, frame_open_next;
  logic                           have_header, have_header_next;
  logic                           ack_pending, ack_pending_next;

  // result of the step
  logic                           bvalid_next, last_next, abort_next, ack_next, start_next;
  logic [7:0]                     bval_next;

  logic                           adv;
  logic [cecbr_pkg::TimeW-1:0]    low_time;
  logic                           is_start, is_pulse, bit_v;
  logic [3:0]                     cnt_inc;
  logic [7:0]                     shifted;
  logic [cecbr_pkg::AddrW-1:0]    dest;

  assign adv      = in_v && (!out_v || m_tready);
  assign s_tready = !in_v || adv;

  assign low_time = in_time - fall_time;
  assign is_start = low_time > {16'd0, start_min_us};
  assign is_pulse = low_time >= {18'd0, one_min_us[15:2]};
  assign bit_v    = (low_time >= {16'd0, one_min_us}) && (low_time <= {16'd0, one_max_us});
  assign cnt_inc  = bit_count + 4'd1;
  assign shifted  = {shift_byte[6:0], bit_v};
  assign dest     = have_header ? header_dest : cecbr_pkg::AddrBroadcast;

  always_comb begin
    prev_level_next  = prev_level;
    fall_time_next   = fall_time;
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    held_byte_next   = held_byte;
    header_dest_next = header_dest;
    frame_open_next  = frame_open;
    have_header_next = have_header;
    ack_pending_next = ack_pending;
    bvalid_next      = 1'b0;
    bval_next        = 8'd0;
    last_next        = 1'b0;
    abort_next       = 1'b0;
    ack_next         = 1'b0;
    start_next       = 1'b0;

    if (in_level != prev_level) begin
      prev_level_next = in_level;
      if (!in_level) begin
        fall_time_next = in_time;
        if (ack_pending && !monitor_mode) begin
          ack_pending_next = 1'b0;
          ack_next         = 1'b1;
        end
      end else if (is_start) begin
        start_next       = 1'b1;
        abort_next       = frame_open;
        frame_open_next  = 1'b0;
        have_header_next = 1'b0;
        header_dest_next = cecbr_pkg::AddrBroadcast;
        phase_next       = PH_BYTE;
        bit_count_next   = 4'd0;
        shift_byte_next  = 8'd0;
        ack_pending_next = 1'b0;
      end else if (is_pulse) begin
        unique case (phase)
          PH_BYTE: begin
            shift_byte_next = shifted;
            bit_count_next  = cnt_inc;
            if (cnt_inc >= cecbr_pkg::BitsPerByte) begin
              held_byte_next = shifted;
              if (!have_header) begin
                header_dest_next = shifted[3:0];
                have_header_next = 1'b1;
              end
              bit_count_next  = 4'd0;
              shift_byte_next = 8'd0;
              phase_next      = PH_EOM;
            end
          end
          PH_EOM: begin
            if (dest != cecbr_pkg::AddrBroadcast && dest == own_address)
              ack_pending_next = 1'b1;
            bvalid_next = 1'b1;
            bval_next   = held_byte;
            last_next   = bit_v;
            if (bit_v) begin
              frame_open_next  = 1'b0;
              have_header_next = 1'b0;
              bit_count_next   = 4'd0;
              shift_byte_next  = 8'd0;
              phase_next       = PH_EOMACK;
            end else begin
              frame_open_next = 1'b1;
              phase_next      = PH_ACK;
            end
          end
          PH_ACK:    phase_next = PH_BYTE;
          PH_EOMACK: phase_next = PH_IDLE;
          default: ; // idle and unused codes ignore bits
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= cecbr_pkg::AddrBroadcast;
      monitor_mode <= 1'b0;
      start_min_us <= cecbr_pkg::StartMinReset;
      one_min_us   <= cecbr_pkg::OneMinReset;
      one_max_us   <= cecbr_pkg::OneMaxReset;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        cecbr_pkg::RegOwnAddress: own_address  <= cfg_data[cecbr_pkg::AddrW-1:0];
        cecbr_pkg::RegMonitor:    monitor_mode <= cfg_data[0];
        cecbr_pkg::RegStartMin:   start_min_us <= cfg_data;
        cecbr_pkg::RegOneMin:     one_min_us   <= cfg_data;
        cecbr_pkg::RegOneMax:     one_max_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v        <= 1'b0;
      out_v       <= 1'b0;
      prev_level  <= 1'b1;
      fall_time   <= '0;
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      held_byte   <= 8'd0;
      header_dest <= cecbr_pkg::AddrBroadcast;
      frame_open  <= 1'b0;
      have_header <= 1'b0;
      ack_pending <= 1'b0;
    end else begin
      if (s_tready) begin
        in_v <= s_tvalid;
      end
      if (adv) begin
        out_v       <= 1'b1;
        prev_level  <= prev_level_next;
        fall_time   <= fall_time_next;
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_byte  <= shift_byte_next;
        held_byte   <= held_byte_next;
        header_dest <= header_dest_next;
        frame_open  <= frame_open_next;
        have_header <= have_header_next;
        ack_pending <= ack_pending_next;
        o_bvalid    <= bvalid_next;
        o_bval      <= bval_next;
        o_last      <= last_next;
        o_abort     <= abort_next;
        o_ack       <= ack_next;
        o_start     <= start_next;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[cecbr_pkg::TimeW:1];
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {4'd0, o_start, o_ack, o_abort, o_bval, o_bvalid};
  assign m_tlast  = o_last;

  `ASSERT_IMPLIES(a_ack_not_monitoring, adv && ack_next, !monitor_mode, "ack requested in monitor mode")
  `ASSERT_IMPLIES(a_start_no_byte, out_v && o_start, !o_bvalid && !o_last, "byte delivered with start bit")
  `ASSERT_IMPLIES(a_abort_needs_start, out_v && o_abort, o_start, "abort without start bit")
  `ASSERT_NEXT(a_start_enters_byte, adv && start_next, phase == PH_BYTE && bit_count == 4'd0, "start bit did not restart byte")

endmodule
